### hdl/flr_pkg.sv
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants for the feedback loop recorder.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = 17;
    localparam int CMP_W       = (POS_W > LEN_W) ? POS_W : LEN_W;

    localparam int VOLT_LIMIT  = 20480;
    localparam int TRIG_HIGH   = 4096;
    localparam int Q15_ONE     = 32768;

    // floor(m / 5) through an offset into positive range and a reciprocal
    localparam logic [22:0] DIV5_RECIP  = 23'd6710887;
    localparam int          DIV5_SHIFT  = 25;
    localparam int          DIV5_BIAS   = 524288;
    localparam int          DIV5_OFFSET = 5 * DIV5_BIAS;

    typedef enum logic [2:0] {
        CFG_FEEDBACK_KNOB    = 3'd0,
        CFG_MIX_KNOB         = 3'd1,
        CFG_FB_CV_GAIN       = 3'd2,
        CFG_MIX_CV_GAIN      = 3'd3,
        CFG_AUX_ROUTED       = 3'd4,
        CFG_LOOP_LENGTH      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LVL_UNKNOWN,
        LVL_LOW,
        LVL_HIGH
    } t_level;

    typedef enum logic [1:0] {
        MODE_ACTIVE,
        MODE_PANIC,
        MODE_FULL
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_AMT,
        S_MUL,
        S_WB
    } t_state;

    typedef struct packed {
        logic signed [15:0] dry_in;
        logic signed [15:0] aux_in;
        logic signed [15:0] trig_in;
        logic signed [15:0] fb_cv;
        logic signed [15:0] mix_cv;
        logic               panic_in;
    } t_in;

    typedef struct packed {
        logic signed [15:0] mix_out;
        logic signed [15:0] aux_out;
        logic               buffer_full;
        logic               aux_internal;
    } t_out;

endpackage

### hdl/flr_amount.sv
// ----------------------------------------------------------------------------
// flr_amount
// Three-stage gain amount: clamp(knob + floor(cv * gain / 20480), 0, 32768).
// ----------------------------------------------------------------------------
module flr_amount (
    input  logic               i_clk,
    input  logic [15:0]        i_knob,
    input  logic signed [15:0] i_cv,
    input  logic signed [16:0] i_gain,
    output logic [16:0]        o_amount
);

    logic signed [32:0] r_prod;
    logic [19:0]        r_quot;
    logic [16:0]        r_amount;

    logic signed [22:0] w_m;
    logic [21:0]        w_u;
    logic [44:0]        w_recip;
    logic signed [22:0] w_sum;
    logic [16:0]        n_amount;

    // divide by 4096 first, then by 5
    assign w_m     = 23'(r_prod >>> 12);
    assign w_u     = 22'(w_m + 23'(flr_pkg::DIV5_OFFSET));
    assign w_recip = 45'(w_u) * 45'(flr_pkg::DIV5_RECIP);
    assign w_sum   = $signed({7'b0, i_knob}) + $signed({3'b0, r_quot})
                   - 23'(flr_pkg::DIV5_BIAS);

    always_comb begin
        if (w_sum < 0) begin
            n_amount = '0;
        end else if (w_sum > 23'(flr_pkg::Q15_ONE)) begin
            n_amount = 17'(flr_pkg::Q15_ONE);
        end else begin
            n_amount = w_sum[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= 33'(i_cv) * 33'(i_gain);
        r_quot   <= w_recip[44:flr_pkg::DIV5_SHIFT];
        r_amount <= n_amount;
    end

    assign o_amount = r_amount;

endmodule

### hdl/feedback_loop_recorder.sv
// ----------------------------------------------------------------------------
// feedback_loop_recorder
// Audio loop recorder with feedback, trigger restart and panic clear.
// ----------------------------------------------------------------------------
// Flow: a sample is taken only in idle and passes through the accept, read, gain,
// multiply and write-back states before another sample is taken; a stalled result
// holds the write-back.
// Reset: synchronous, active low; the store reads as zero at or above a fill
// mark, so no clearing pass is needed after reset or panic.
module feedback_loop_recorder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  flr_pkg::t_in     i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output flr_pkg::t_out    o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [16:0]      i_cfg_data
);

    typedef struct packed {
        flr_pkg::t_level level;
        logic            fired;
    } t_edge;

    function automatic t_edge edge_step(flr_pkg::t_level lvl, logic hi, logic lo);
        t_edge e;
        e.level = lvl;
        e.fired = 1'b0;
        unique case (lvl)
            flr_pkg::LVL_LOW: begin
                if (hi) begin
                    e.level = flr_pkg::LVL_HIGH;
                    e.fired = 1'b1;
                end
            end
            flr_pkg::LVL_HIGH: begin
                if (lo) e.level = flr_pkg::LVL_LOW;
            end
            default: begin
                if (hi) e.level = flr_pkg::LVL_HIGH;
                else if (lo) e.level = flr_pkg::LVL_LOW;
            end
        endcase
        return e;
    endfunction

    logic [15:0]        r_feedback_knob;
    logic [15:0]        r_mix_knob;
    logic signed [16:0] r_fb_cv_gain;
    logic signed [16:0] r_mix_cv_gain;
    logic               r_aux_routed;
    logic [16:0]        r_loop_length;

    flr_pkg::t_state r_state, n_state;
    flr_pkg::t_level r_trig_level, r_panic_level;
    flr_pkg::t_mode  r_mode, n_mode;

    logic [flr_pkg::POS_W-1:0] r_position, n_position;
    logic [flr_pkg::POS_W-1:0] r_hwm, n_hwm;
    logic [flr_pkg::POS_W-1:0] w_pos_inc;
    logic                      r_hit;

    flr_pkg::t_in       r_item;
    logic signed [15:0] r_rd;
    logic signed [15:0] r_stored;
    logic signed [34:0] r_fb_prod;
    logic signed [33:0] r_dry;
    logic signed [33:0] r_wet;

    logic signed [15:0] r_held_aux;
    logic               r_held_full;
    logic               r_held_int;

    logic               r_out_valid;
    flr_pkg::t_out      r_out;

    logic signed [15:0] mem [flr_pkg::STORE_DEPTH];

    t_edge  w_trig, w_panic;
    logic   w_accept;
    logic   w_wb_go;
    logic   w_wr_en;
    logic [flr_pkg::CMP_W-1:0] w_len;

    logic [16:0]        w_famt, w_mamt;
    logic signed [16:0] w_src;
    logic signed [34:0] w_mix_sum;
    logic signed [20:0] w_wr_sum;
    logic signed [15:0] w_wr_data;
    flr_pkg::t_out      w_out;

    flr_amount u_famt (
        .i_clk    (i_clk),
        .i_knob   (r_feedback_knob),
        .i_cv     (i_in.fb_cv),
        .i_gain   (r_fb_cv_gain),
        .o_amount (w_famt)
    );

    flr_amount u_mamt (
        .i_clk    (i_clk),
        .i_knob   (r_mix_knob),
        .i_cv     (i_in.mix_cv),
        .i_gain   (r_mix_cv_gain),
        .o_amount (w_mamt)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == flr_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_wb_go     = (r_state == flr_pkg::S_WB) && (!r_out_valid || i_out_ready);
    assign w_wr_en     = w_wb_go && (r_mode == flr_pkg::MODE_ACTIVE);

    assign w_trig  = edge_step(r_trig_level,
                               i_in.trig_in >= 16'sd4096,
                               i_in.trig_in <= 16'sd0);
    assign w_panic = edge_step(r_panic_level, i_in.panic_in, !i_in.panic_in);

    assign w_len = (flr_pkg::CMP_W'(r_loop_length) < flr_pkg::CMP_W'(flr_pkg::STORE_DEPTH))
                 ? flr_pkg::CMP_W'(r_loop_length)
                 : flr_pkg::CMP_W'(flr_pkg::STORE_DEPTH);

    always_comb begin
        n_position = r_position;
        n_hwm      = r_hwm;
        if (w_trig.fired) n_position = '0;
        if (w_panic.fired) begin
            n_position = '0;
            n_hwm      = '0;
        end
        priority if (w_panic.fired) begin
            n_mode = flr_pkg::MODE_PANIC;
        end else if (flr_pkg::CMP_W'(n_position) < w_len) begin
            n_mode = flr_pkg::MODE_ACTIVE;
        end else begin
            n_mode = flr_pkg::MODE_FULL;
        end
    end

    assign w_pos_inc = r_position + 1'b1;

    assign w_src     = r_aux_routed ? 17'(r_item.aux_in)
                                    : 17'(r_item.aux_in) + 17'(r_stored);
    assign w_mix_sum = 35'(r_dry) + 35'(r_wet);
    assign w_wr_sum  = 21'(r_item.dry_in) + 21'(r_fb_prod >>> 15);

    always_comb begin
        if (w_wr_sum > 21'sd20480) begin
            w_wr_data = 16'(flr_pkg::VOLT_LIMIT);
        end else if (w_wr_sum < -21'sd20480) begin
            w_wr_data = -16'(flr_pkg::VOLT_LIMIT);
        end else begin
            w_wr_data = w_wr_sum[15:0];
        end
    end

    always_comb begin
        w_out.mix_out      = '0;
        w_out.aux_out      = r_held_aux;
        w_out.buffer_full  = r_held_full;
        w_out.aux_internal = r_held_int;
        unique case (r_mode)
            flr_pkg::MODE_ACTIVE: begin
                w_out.mix_out      = w_mix_sum[30:15];
                w_out.aux_out      = r_stored;
                w_out.buffer_full  = 1'b0;
                w_out.aux_internal = !r_aux_routed;
            end
            flr_pkg::MODE_PANIC: begin
                w_out.aux_out = '0;
            end
            default: begin
                w_out.buffer_full = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            flr_pkg::S_IDLE:  if (w_accept) n_state = flr_pkg::S_RECIP;
            flr_pkg::S_RECIP: n_state = flr_pkg::S_AMT;
            flr_pkg::S_AMT:   n_state = flr_pkg::S_MUL;
            flr_pkg::S_MUL:   n_state = flr_pkg::S_WB;
            flr_pkg::S_WB:    if (w_wb_go) n_state = flr_pkg::S_IDLE;
            default:          n_state = flr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback_knob    <= 16'd16384;
            r_mix_knob         <= 16'd16384;
            r_fb_cv_gain       <= '0;
            r_mix_cv_gain      <= '0;
            r_aux_routed       <= 1'b0;
            r_loop_length      <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                flr_pkg::CFG_FEEDBACK_KNOB:    r_feedback_knob    <= i_cfg_data[15:0];
                flr_pkg::CFG_MIX_KNOB:         r_mix_knob         <= i_cfg_data[15:0];
                flr_pkg::CFG_FB_CV_GAIN:       r_fb_cv_gain       <= $signed(i_cfg_data);
                flr_pkg::CFG_MIX_CV_GAIN:      r_mix_cv_gain      <= $signed(i_cfg_data);
                flr_pkg::CFG_AUX_ROUTED:       r_aux_routed       <= i_cfg_data[0];
                flr_pkg::CFG_LOOP_LENGTH:      r_loop_length      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= flr_pkg::S_IDLE;
            r_trig_level  <= flr_pkg::LVL_UNKNOWN;
            r_panic_level <= flr_pkg::LVL_UNKNOWN;
            r_mode        <= flr_pkg::MODE_ACTIVE;
            r_position    <= '0;
            r_hwm         <= '0;
            r_held_aux    <= '0;
            r_held_full   <= 1'b0;
            r_held_int    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_trig_level  <= w_trig.level;
                r_panic_level <= w_panic.level;
                r_mode        <= n_mode;
                r_position    <= n_position;
                r_hwm         <= n_hwm;
            end
            if (w_wb_go) begin
                r_out_valid  <= 1'b1;
                r_held_aux   <= w_out.aux_out;
                r_held_full  <= w_out.buffer_full;
                r_held_int   <= w_out.aux_internal;
                if (r_mode == flr_pkg::MODE_ACTIVE) begin
                    r_position <= w_pos_inc;
                    if (w_pos_inc > r_hwm) r_hwm <= w_pos_inc;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
            r_hit  <= n_position < n_hwm;
        end
        if (r_state == flr_pkg::S_RECIP) begin
            r_stored <= r_hit ? r_rd : 16'sd0;
        end
        if (r_state == flr_pkg::S_MUL) begin
            r_fb_prod <= 35'(w_src) * 35'($signed({1'b0, w_famt}));
            r_dry     <= 34'($signed(18'(flr_pkg::Q15_ONE) - {1'b0, w_mamt}))
                       * 34'(r_item.dry_in);
            r_wet     <= 34'($signed({1'b0, w_mamt})) * 34'(r_stored);
        end
        if (w_wb_go) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_position[flr_pkg::ADDR_W-1:0]] <= w_wr_data;
        end
        r_rd <= mem[n_position[flr_pkg::ADDR_W-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### tb/feedback_loop_recorder_test.sv
// ----------------------------------------------------------------------------
// feedback_loop_recorder_test
// Self-checking bench for the feedback loop recorder. A scoreboard class
// keeps its own loop store, position, edge detectors and register copies,
// predicts one result per sample transfer and checks every result transfer
// in order. Directed samples cover field extremes, trigger and panic edges
// and the full flag; random phases sweep gains, routing and loop lengths
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class recorder_board;
    bit [15:0]                knob_fb;
    bit [15:0]                knob_mix;
    logic signed [16:0]       gain_fb;
    logic signed [16:0]       gain_mix;
    bit                       routed;
    bit [16:0]                length_reg;
    shortint                  samples[int];
    longint                   wr_pos;
    flr_pkg::t_level          trig_state;
    flr_pkg::t_level          panic_state;
    logic signed [15:0]       last_aux;
    bit                       last_full;
    bit                       last_internal;
    flr_pkg::t_out            outputs_due[$];
    int                       mismatches;

    function new();
        knob_fb       = 16'd16384;
        knob_mix      = 16'd16384;
        gain_fb       = '0;
        gain_mix      = '0;
        routed        = 1'b0;
        length_reg    = 17'h10000;
        wr_pos        = 0;
        trig_state    = flr_pkg::LVL_UNKNOWN;
        panic_state   = flr_pkg::LVL_UNKNOWN;
        last_aux      = '0;
        last_full     = 1'b0;
        last_internal = 1'b0;
        mismatches    = 0;
    endfunction

    function longint fdiv(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Schmitt detector; returns 1 only on a low-to-high crossing
    function bit crossed(inout flr_pkg::t_level lvl, input longint v, input longint th);
        bit hit;
        hit = 1'b0;
        case (lvl)
            flr_pkg::LVL_LOW: begin
                if (v >= th) begin
                    lvl = flr_pkg::LVL_HIGH;
                    hit = 1'b1;
                end
            end
            flr_pkg::LVL_HIGH: begin
                if (v <= 0) begin
                    lvl = flr_pkg::LVL_LOW;
                end
            end
            default: begin
                if (v >= th) begin
                    lvl = flr_pkg::LVL_HIGH;
                end else if (v <= 0) begin
                    lvl = flr_pkg::LVL_LOW;
                end
            end
        endcase
        return hit;
    endfunction

    function longint gain_amount(input longint knob, input longint cv, input longint gain);
        return clip(knob + fdiv(cv * gain, 5 * 4096), 0, flr_pkg::Q15_ONE);
    endfunction

    function void set_register(input logic [2:0] idx, input logic [16:0] d);
        case (idx)
            flr_pkg::CFG_FEEDBACK_KNOB:    knob_fb    = d[15:0];
            flr_pkg::CFG_MIX_KNOB:         knob_mix   = d[15:0];
            flr_pkg::CFG_FB_CV_GAIN:       gain_fb    = d;
            flr_pkg::CFG_MIX_CV_GAIN:      gain_mix   = d;
            flr_pkg::CFG_AUX_ROUTED:       routed     = d[0];
            flr_pkg::CFG_LOOP_LENGTH:      length_reg = d;
            default: ;
        endcase
    endfunction

    function void accept_sample(input flr_pkg::t_in x);
        longint        span;
        longint        cur;
        longint        famt;
        longint        mamt;
        longint        src;
        longint        dry;
        longint        mixed;
        flr_pkg::t_out r;
        dry   = $signed(x.dry_in);
        span  = (length_reg < flr_pkg::STORE_DEPTH) ? length_reg : flr_pkg::STORE_DEPTH;
        mixed = 0;
        if (crossed(trig_state, $signed(x.trig_in), flr_pkg::TRIG_HIGH)) begin
            wr_pos = 0;
        end
        if (crossed(panic_state, x.panic_in, 1)) begin
            samples.delete();
            wr_pos   = 0;
            last_aux = '0;
        end else if (wr_pos < span) begin
            cur  = samples.exists(int'(wr_pos)) ? samples[int'(wr_pos)] : 0;
            famt = gain_amount(knob_fb, $signed(x.fb_cv), gain_fb);
            mamt = gain_amount(knob_mix, $signed(x.mix_cv), gain_mix);
            last_full = 1'b0;
            if (routed) begin
                last_internal = 1'b0;
                src = $signed(x.aux_in);
            end else begin
                last_internal = 1'b1;
                src = $signed(x.aux_in) + cur;
            end
            last_aux = cur[15:0];
            mixed = fdiv((flr_pkg::Q15_ONE - mamt) * dry + mamt * cur, flr_pkg::Q15_ONE);
            samples[int'(wr_pos)] = shortint'(clip(dry + fdiv(src * famt, flr_pkg::Q15_ONE),
                                                   -flr_pkg::VOLT_LIMIT, flr_pkg::VOLT_LIMIT));
            wr_pos = wr_pos + 1;
        end else begin
            last_full = 1'b1;
        end
        r.mix_out      = mixed[15:0];
        r.aux_out      = last_aux;
        r.buffer_full  = last_full;
        r.aux_internal = last_internal;
        outputs_due.push_back(r);
    endfunction

    task report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_output(input flr_pkg::t_out got);
        flr_pkg::t_out want;
        if (outputs_due.size() == 0) begin
            report("result transfer with no sample pending");
            return;
        end
        want = outputs_due.pop_front();
        if (got.mix_out !== want.mix_out) begin
            report($sformatf("mix_out got %0d expected %0d", got.mix_out, want.mix_out));
        end
        if (got.aux_out !== want.aux_out) begin
            report($sformatf("aux_out got %0d expected %0d", got.aux_out, want.aux_out));
        end
        if (got.buffer_full !== want.buffer_full) begin
            report($sformatf("buffer_full got %0b expected %0b",
                             got.buffer_full, want.buffer_full));
        end
        if (got.aux_internal !== want.aux_internal) begin
            report($sformatf("aux_internal got %0b expected %0b",
                             got.aux_internal, want.aux_internal));
        end
    endtask

    function int pending();
        return outputs_due.size();
    endfunction
endclass

module feedback_loop_recorder_test;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SETTLE       = 10;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_ready;
    flr_pkg::t_in  i_in        = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    flr_pkg::t_out o_out;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [16:0]   i_cfg_data  = '0;

    recorder_board board;
    bit            calm       = 1'b0;
    int            stall_left = 0;
    int            cycles     = 0;

    feedback_loop_recorder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check each transfer, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_output(o_out);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic flr_pkg::t_in item_of(input logic [15:0] a, input logic [15:0] x,
                                             input logic [15:0] trig, input logic [15:0] fcv,
                                             input logic [15:0] mcv, input logic pan);
        flr_pkg::t_in it;
        it.dry_in   = a;
        it.aux_in   = x;
        it.trig_in  = trig;
        it.fb_cv    = fcv;
        it.mix_cv   = mcv;
        it.panic_in = pan;
        return it;
    endfunction

    function automatic logic [15:0] wide_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // mostly low so the loop gets recorded; rare rises, mid-band and noise
    function automatic logic [15:0] trigger_value();
        logic [15:0] v;
        case ($urandom_range(0, 29))
            0:       v = 16'($urandom_range(flr_pkg::TRIG_HIGH, 32767));
            1:       v = 16'($urandom);
            2:       v = 16'($urandom_range(1, flr_pkg::TRIG_HIGH - 1));
            3:       v = 16'(-int'($urandom_range(1, 32768)));
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic flr_pkg::t_in random_item();
        return item_of(wide_value(), wide_value(), trigger_value(), wide_value(),
                       wide_value(), $urandom_range(0, 59) == 0);
    endfunction

    task automatic send_sample(input flr_pkg::t_in x);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.accept_sample(x);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_register(idx, d);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic settings(input logic [16:0] fk, input logic [16:0] mk,
                            input logic [16:0] fg, input logic [16:0] mg,
                            input logic [16:0] ar, input logic [16:0] ll);
        write_reg(flr_pkg::CFG_FEEDBACK_KNOB, fk);
        write_reg(flr_pkg::CFG_MIX_KNOB, mk);
        write_reg(flr_pkg::CFG_FB_CV_GAIN, fg);
        write_reg(flr_pkg::CFG_MIX_CV_GAIN, mg);
        write_reg(flr_pkg::CFG_AUX_ROUTED, ar);
        write_reg(flr_pkg::CFG_LOOP_LENGTH, ll);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [16:0] fk, input logic [16:0] mk,
                             input logic [16:0] fg, input logic [16:0] mg,
                             input logic [16:0] ar, input logic [16:0] ll, input int n);
        drain();
        settings(fk, mk, fg, mg, ar, ll);
        repeat (n) send_sample(random_item());
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unused indexes must leave every register alone
        write_reg(CFG_SPARE_LO, 17'h1ABCD);
        write_reg(CFG_SPARE_HI, 17'h0FFFF);
        // gains +1.0 / -1.0 (17'h18000), internal path, loop of five
        settings(17'h08000, 17'h04000, 17'h08000, 17'h18000, 17'h0, 17'd5);

        // detectors start unknown: high levels set state without an edge
        send_sample(item_of(16'h7FFF, 16'h8000, 16'd4096, 16'h7FFF, 16'h8000, 1'b1));
        send_sample(item_of(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 1'b0));
        send_sample(item_of(16'd20000, 16'd20000, 16'd100, 16'h0, 16'h0, 1'b0));
        send_sample(item_of(16'hFFFF, 16'd1, 16'd4095, 16'd5, -16'd5, 1'b0));
        // trigger rise restarts the loop
        send_sample(item_of(16'd1000, -16'd1000, 16'd4096, 16'h0, 16'h0, 1'b0));
        send_sample(item_of(16'd12345, -16'd23456, 16'h0, 16'd8192, -16'd8192, 1'b0));
        send_sample(item_of(-16'd20480, 16'd20480, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0));
        send_sample(item_of(16'd20480, -16'd20480, 16'h0, 16'h8000, 16'h8000, 1'b0));
        send_sample(item_of(16'd3, 16'd4, 16'h0, 16'h0, 16'h0, 1'b0));
        // loop length reached: full, aux held
        send_sample(item_of(16'd7, 16'd7, 16'h0, 16'h0, 16'h0, 1'b0));
        send_sample(item_of(16'd8, 16'd8, 16'h0, 16'h0, 16'h0, 1'b0));
        // trigger and panic rise together
        send_sample(item_of(16'd9, 16'd9, 16'h7FFF, 16'h0, 16'h0, 1'b1));
        send_sample(item_of(16'd10, 16'd10, 16'h8000, 16'h0, 16'h0, 1'b1));
        send_sample(item_of(16'd11, 16'd11, 16'h0, 16'h0, 16'h0, 1'b0));
        // panic alone
        send_sample(item_of(16'd12, 16'd12, 16'h0, 16'h0, 16'h0, 1'b1));
        send_sample(item_of(16'h5555, 16'hAAAA, 16'h0, 16'h0, 16'h0, 1'b0));
        send_sample(item_of(16'hAAAA, 16'h5555, 16'h0, 16'h7FFF, 16'h8000, 1'b0));

        // zero loop length: full at once, external routing
        drain();
        settings(17'h0FFFF, 17'h0FFFF, 17'h10000, 17'h0FFFF, 17'h1, 17'h0);
        send_sample(item_of(16'd100, 16'd200, 16'h0, 16'h0, 16'h0, 1'b0));
        send_sample(item_of(16'd300, 16'd400, 16'd5000, 16'h0, 16'h0, 1'b0));

        run_phase(17'd16384, 17'd16384, 17'h0, 17'h0, 17'h0, 17'd16, 130);
        run_phase(17'h08000, 17'h0, 17'h08000, 17'h18000, 17'h1, 17'd1, 100);
        run_phase(17'h0, 17'h08000, 17'h10000, 17'h0FFFF, 17'h0, 17'd100, 130);
        run_phase(17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h10000, 17'h1, 17'd40, 120);
        // length dropped below the current position
        run_phase(17'd20000, 17'd10000, 17'h0, 17'h0, 17'h0, 17'd2, 25);
        run_phase(17'd20000, 17'd10000, 17'h0, 17'h0, 17'h0, 17'h0, 25);
        run_phase(17'($urandom_range(0, 32768)), 17'($urandom_range(0, 32768)),
                  17'($urandom), 17'($urandom), 17'($urandom_range(0, 1)),
                  17'($urandom_range(1, 64)), 140);
        drain();
        calm = 1'b1;
        run_phase(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                  17'h0, 17'h1FFFF, 140);

        drain();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### filelist.f
hdl/flr_pkg.sv
hdl/flr_amount.sv
hdl/feedback_loop_recorder.sv
tb/feedback_loop_recorder_test.sv
